@@ rtl/variable_message_ring_manager_macros.svh @@
`ifndef VARIABLE_MESSAGE_RING_MANAGER_MACROS_SVH
`define VARIABLE_MESSAGE_RING_MANAGER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define VMRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define VMRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vmrm_pkg.sv @@
package vmrm_pkg;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_PEEK    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_MAX_MESSAGE_LINES = 1'b0,
    REG_TOTAL_LINES       = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_WRITE,
    S_PUSH
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] msg_size;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  line_index;
    logic [15:0] head_size;
    logic [10:0] free_count;
  } out_beat_t;

  typedef struct packed {
    logic [9:0]  next_pos;
    logic [10:0] used;
  } adv_t;

  localparam logic [6:0]  MAX_LINES_RST   = 7'd2;
  localparam logic [10:0] TOTAL_LINES_RST = 11'd1024;
  localparam logic [10:0] MIN_TOTAL       = 11'd4;
  localparam logic [6:0]  MIN_MAX         = 7'd1;
  localparam logic [6:0]  MAX_MAX         = 7'd64;

  function automatic logic [10:0] clamp_total(input logic [10:0] raw,
                                              input logic [10:0] cap);
    logic [10:0] t;
    t = raw;
    if (t < MIN_TOTAL) t = MIN_TOTAL;
    if (t > cap) t = cap;
    return t;
  endfunction

  // largest message, limited to half the ring
  function automatic logic [6:0] clamp_max(input logic [6:0] raw,
                                           input logic [10:0] t);
    logic [6:0] m;
    m = raw;
    if (m < MIN_MAX) m = MIN_MAX;
    if (m > MAX_MAX) m = MAX_MAX;
    if ({3'b000, m, 1'b0} > t) m = t[7:1];
    return m;
  endfunction

  // position after a message, wrapping past the last start slot
  function automatic adv_t advance(input logic [9:0] pos, input logic [6:0] len,
                                   input logic [10:0] t, input logic [6:0] m);
    logic [10:0] last;
    logic [10:0] np;
    logic [10:0] skip;
    adv_t        r;
    last = t - {4'b0000, m};
    np   = {1'b0, pos} + {4'b0000, len};
    skip = '0;
    if (np > last) begin
      if (np < t) skip = t - np;
      np = '0;
    end
    r.next_pos = np[9:0];
    r.used     = {4'b0000, len} + skip;
    return r;
  endfunction

endpackage

@@ rtl/vmrm_ram.sv @@
module vmrm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vmrm_lines.sv @@
module vmrm_lines #(
  parameter int LINE_BYTES   = 64,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] size_i,
  output logic [16:0] lines_o
);

  // exact floor division by reciprocal for any 17-bit dividend
  localparam int     XW     = 17;
  localparam int     Shift  = XW + $clog2(LINE_BYTES);
  localparam longint Recip  = ((longint'(1) << Shift) + longint'(LINE_BYTES) - 1)
                              / longint'(LINE_BYTES);
  localparam logic [18:0] RecipV = 19'(Recip);

  logic [16:0] dividend;
  logic [35:0] prod;
  logic [16:0] quot;
  logic [16:0] lines_q;

  assign dividend = {1'b0, size_i} + 17'(HEADER_BYTES - 1);
  assign prod     = {19'b0, dividend} * {17'b0, RecipV};
  assign quot     = 17'(prod >> Shift);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lines_q <= quot + 17'd1;
    end
  end

  assign lines_o = lines_q;

endmodule

@@ rtl/variable_message_ring_manager.sv @@
// a beat passes the calc and exec states, a successful commit also the write state;
//   new beats are taken only in idle, after the last result; the header memory read,
//   the line-count multiplier and the single memory write port set this pace
// reset: positions 0, free count equal to the ring size, the init state writes
//   a zero header at line 0 while the input stalls; register writes empty the ring
module variable_message_ring_manager #(
  parameter int RING_LINES   = 1024,
  parameter int LINE_BYTES   = 64,
  parameter int HEADER_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vmrm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vmrm_pkg::out_beat_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [10:0]         cfg_wdata_i
);

`include "variable_message_ring_manager_macros.svh"

  // only lines below the capped ring size are ever addressed
  localparam int          CapLines = (RING_LINES < 1024) ? RING_LINES : 1024;
  localparam int          AddrW    = $clog2(CapLines);
  localparam logic [10:0] CapL     = 11'(CapLines);
  localparam logic [10:0] RstTotal = vmrm_pkg::clamp_total(vmrm_pkg::TOTAL_LINES_RST, CapL);
  localparam logic [6:0]  RstMax   = vmrm_pkg::clamp_max(vmrm_pkg::MAX_LINES_RST, RstTotal);

  vmrm_pkg::state_e state_q, state_d;

  // configuration, raw and clamped
  logic [6:0]  max_raw_q, max_raw_d;
  logic [10:0] total_raw_q, total_raw_d;
  logic [10:0] t_q, t_d;
  logic [6:0]  m_q, m_d;

  // ring pointers and free count
  logic [9:0]  write_line_q, write_line_d;
  logic [9:0]  read_line_q, read_line_d;
  logic [10:0] free_lines_q, free_lines_d;

  // operation in flight
  vmrm_pkg::op_e       op_q;
  logic [15:0]         size_q;
  logic [15:0]         head_q;
  logic [9:0]          hdr_addr_q;
  vmrm_pkg::out_beat_t res_q, res_d;

  // result register
  logic                out_valid_q;
  vmrm_pkg::out_beat_t out_data_q;
  logic                out_load;
  vmrm_pkg::out_beat_t out_load_data;
  logic                can_push;

  // header memory ports
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [15:0]      mem_rdata;

  // line count unit
  logic [15:0] lines_size;
  logic [16:0] len_q;

  logic           accept;
  logic           commit_ok;
  logic [10:0]    twice_m;
  logic [6:0]     len_sat;
  logic [9:0]     adv_pos;
  vmrm_pkg::adv_t adv;
  logic [11:0]    free_sum;

  assign in_stall_o = (state_q != vmrm_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_push   = !out_valid_q || !out_stall_i;

  // header read is issued with the accept, data is there in the calc cycle
  assign mem_re = accept;

  vmrm_ram #(
    .Width(16),
    .Depth(CapLines)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(read_line_q[AddrW-1:0]),
    .rdata_o(mem_rdata)
  );

  // release sizes its step from the stored header, commit from the beat
  assign lines_size = (op_q == vmrm_pkg::OP_RELEASE) ? mem_rdata : size_q;

  vmrm_lines #(
    .LINE_BYTES  (LINE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_lines (
    .clk_i  (clk_i),
    .en_i   (state_q == vmrm_pkg::S_CALC),
    .size_i (lines_size),
    .lines_o(len_q)
  );

  // configuration next values, clamped copies follow in the same edge
  always_comb begin
    max_raw_d   = max_raw_q;
    total_raw_d = total_raw_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        vmrm_pkg::REG_MAX_MESSAGE_LINES: max_raw_d   = cfg_wdata_i[6:0];
        vmrm_pkg::REG_TOTAL_LINES:       total_raw_d = cfg_wdata_i;
        default: ;
      endcase
    end
    t_d = vmrm_pkg::clamp_total(total_raw_d, CapL);
    m_d = vmrm_pkg::clamp_max(max_raw_d, t_d);
  end

  // shared advance for commit and release
  assign twice_m = {3'b000, m_q, 1'b0};
  assign len_sat = (len_q > {10'b0, m_q}) ? m_q : len_q[6:0];
  assign adv_pos = (op_q == vmrm_pkg::OP_COMMIT) ? write_line_q : read_line_q;
  assign adv     = vmrm_pkg::advance(adv_pos, len_sat, t_q, m_q);
  assign free_sum = {1'b0, free_lines_q} + {1'b0, adv.used};

  // fsm, operation decode and memory writes
  always_comb begin
    state_d       = state_q;
    write_line_d  = write_line_q;
    read_line_d   = read_line_q;
    free_lines_d  = free_lines_q;
    res_d         = res_q;
    commit_ok     = 1'b0;
    out_load      = 1'b0;
    out_load_data = res_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;

    case (state_q)
      vmrm_pkg::S_INIT: begin
        // clear the line 0 header once after reset
        mem_we  = 1'b1;
        state_d = vmrm_pkg::S_IDLE;
      end

      vmrm_pkg::S_IDLE: begin
        if (accept) state_d = vmrm_pkg::S_CALC;
      end

      vmrm_pkg::S_CALC: begin
        state_d = vmrm_pkg::S_EXEC;
      end

      vmrm_pkg::S_EXEC: begin
        res_d.status     = vmrm_pkg::ST_OK;
        res_d.line_index = write_line_q;
        res_d.head_size  = '0;
        case (op_q)
          vmrm_pkg::OP_RESERVE, vmrm_pkg::OP_COMMIT: begin
            if (free_lines_q < twice_m) begin
              res_d.status = vmrm_pkg::ST_NO_SPACE;
            end else if (op_q == vmrm_pkg::OP_COMMIT) begin
              if (size_q == 16'd0 || len_q > {10'b0, m_q}) begin
                res_d.status = vmrm_pkg::ST_BAD_SIZE;
              end else begin
                commit_ok    = 1'b1;
                write_line_d = adv.next_pos;
                free_lines_d = (free_lines_q >= adv.used) ? free_lines_q - adv.used : '0;
                // zero sentinel first, size header in the next cycle
                mem_we       = 1'b1;
                mem_waddr    = adv.next_pos[AddrW-1:0];
              end
            end
          end
          vmrm_pkg::OP_PEEK, vmrm_pkg::OP_RELEASE: begin
            res_d.line_index = read_line_q;
            res_d.head_size  = head_q;
            if (head_q == 16'd0) begin
              res_d.status = vmrm_pkg::ST_EMPTY;
            end else if (op_q == vmrm_pkg::OP_RELEASE) begin
              read_line_d  = adv.next_pos;
              free_lines_d = (free_sum > {1'b0, t_q}) ? t_q : free_sum[10:0];
            end
          end
          default: ;
        endcase
        res_d.free_count = free_lines_d;

        if (commit_ok) begin
          state_d = vmrm_pkg::S_WRITE;
        end else if (can_push) begin
          out_load      = 1'b1;
          out_load_data = res_d;
          state_d       = vmrm_pkg::S_IDLE;
        end else begin
          state_d = vmrm_pkg::S_PUSH;
        end
      end

      vmrm_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_addr_q[AddrW-1:0];
        mem_wdata = size_q;
        if (can_push) begin
          out_load = 1'b1;
          state_d  = vmrm_pkg::S_IDLE;
        end else begin
          state_d = vmrm_pkg::S_PUSH;
        end
      end

      vmrm_pkg::S_PUSH: begin
        if (can_push) begin
          out_load = 1'b1;
          state_d  = vmrm_pkg::S_IDLE;
        end
      end

      default: state_d = vmrm_pkg::S_INIT;
    endcase

    // register write empties the ring; user must write only while idle, not enforced
    if (cfg_we_i) begin
      write_line_d = '0;
      read_line_d  = '0;
      free_lines_d = t_d;
      mem_we       = 1'b1;
      mem_waddr    = '0;
      mem_wdata    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vmrm_pkg::S_INIT;
      max_raw_q    <= vmrm_pkg::MAX_LINES_RST;
      total_raw_q  <= vmrm_pkg::TOTAL_LINES_RST;
      t_q          <= RstTotal;
      m_q          <= RstMax;
      write_line_q <= '0;
      read_line_q  <= '0;
      free_lines_q <= RstTotal;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      max_raw_q    <= max_raw_d;
      total_raw_q  <= total_raw_d;
      t_q          <= t_d;
      m_q          <= m_d;
      write_line_q <= write_line_d;
      read_line_q  <= read_line_d;
      free_lines_q <= free_lines_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_data_i.opcode;
      size_q <= in_data_i.msg_size;
    end
    if (state_q == vmrm_pkg::S_CALC) begin
      head_q <= mem_rdata;
    end
    if (state_q == vmrm_pkg::S_EXEC) begin
      res_q      <= res_d;
      hdr_addr_q <= write_line_q;
    end
    if (out_load) begin
      out_data_q <= out_load_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ring pointers stay inside the ring in use
  `VMRM_ASSERT_NOW(a_write_in_ring, 1'b1, 11'(write_line_q) < t_q, "write line outside ring")
  `VMRM_ASSERT_NOW(a_read_in_ring, 1'b1, 11'(read_line_q) < t_q, "read line outside ring")
  // free count is never above the ring size
  `VMRM_ASSERT_NOW(a_free_bounded, 1'b1, free_lines_q <= t_q, "free count above ring size")
  // a successful commit writes its size header in the following cycle
  `VMRM_ASSERT_NXT(a_header_follows, commit_ok, state_q == vmrm_pkg::S_WRITE, "header write missed")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import vmrm_pkg::*;

  localparam int unsigned RING_LINES   = 1024;
  localparam int unsigned LINE_BYTES   = 64;
  localparam int unsigned HEADER_BYTES = 8;

  // receiver hold-off used to back the block up into its input
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned N_PHASES = 14;
  localparam int unsigned PHASE_BEATS = 80;
  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  // one row of the directed table: a register write or an input beat,
  // optionally with a hand-typed reply
  typedef struct {
    row_kind_e   kind;
    reg_e        cfg_reg;
    logic [10:0] cfg_val;
    in_beat_t    beat;
    bit          typed;
    out_beat_t   want;
  } dir_row_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_beat_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  logic        in_stall;
  logic        out_valid;
  out_beat_t   out_data;

  // shared between the sender, the receiver and the reply checker
  out_beat_t   reply_q [$];
  int unsigned err_cnt  = 0;
  bit          hold_req = 1'b0;
  bit          tx_flat  = 1'b0;

  // mirror of the ring: raw register values, positions, free lines, headers
  int unsigned cfg_max_raw   = 2;
  int unsigned cfg_total_raw = 1024;
  int unsigned wr_pos  = 0;
  int unsigned rd_pos  = 0;
  int unsigned free_ln = 1024;
  logic [15:0] hdr_mem [RING_LINES];

  dir_row_t    dir_tab [$];

  logic [10:0] phase_max [10] = '{11'd2, 11'd1, 11'd64, 11'd64, 11'd3,
                                  11'd7, 11'h7FF, 11'd0, 11'd17, 11'd5};
  logic [10:0] phase_total [10] = '{11'd1024, 11'd4, 11'd128, 11'd1024, 11'd10,
                                    11'h7FF, 11'd200, 11'd0, 11'd100, 11'd37};

  always #5 clk_i = ~clk_i;

  variable_message_ring_manager #(
    .RING_LINES  (RING_LINES),
    .LINE_BYTES  (LINE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // ring size in effect, clamped to the physical ring
  function automatic int unsigned ring_size();
    int unsigned t;
    t = cfg_total_raw;
    if (t < 4) t = 4;
    if (t > RING_LINES) t = RING_LINES;
    return t;
  endfunction

  // largest message in lines, clamped and limited to half the ring
  function automatic int unsigned msg_cap();
    int unsigned m;
    m = cfg_max_raw;
    if (m < 1) m = 1;
    if (m > 64) m = 64;
    if (2 * m > ring_size()) m = ring_size() / 2;
    return m;
  endfunction

  function automatic int unsigned line_count(int unsigned sz);
    return (sz + HEADER_BYTES - 1) / LINE_BYTES + 1;
  endfunction

  // next position after a message; wraps to line 0 past the last start slot
  // and charges the skipped tail lines as used
  function automatic int unsigned step_pos(int unsigned pos, int unsigned len,
                                           output int unsigned used);
    int unsigned t;
    int unsigned np;
    int unsigned skip;
    t    = ring_size();
    np   = pos + len;
    skip = 0;
    if (np > t - msg_cap()) begin
      skip = (np < t) ? t - np : 0;
      np   = 0;
    end
    used = len + skip;
    return np;
  endfunction

  // any register write empties the ring
  function automatic void ring_empty();
    wr_pos  = 0;
    rd_pos  = 0;
    free_ln = ring_size();
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
  endfunction

  // reply for one accepted beat, updating the mirror
  function automatic out_beat_t ring_reply(in_beat_t b);
    out_beat_t   r;
    int unsigned m;
    int unsigned len;
    int unsigned used;
    int unsigned np;
    int unsigned hd;
    m = msg_cap();
    r.status    = ST_OK;
    r.head_size = '0;
    if (b.opcode == OP_RESERVE || b.opcode == OP_COMMIT) begin
      r.line_index = wr_pos[9:0];
      // room check comes ahead of the size check
      if (free_ln < 2 * m) begin
        r.status = ST_NO_SPACE;
      end else if (b.opcode == OP_COMMIT) begin
        len = line_count(32'(b.msg_size));
        if (b.msg_size == 0 || len > m) begin
          r.status = ST_BAD_SIZE;
        end else begin
          np = step_pos(wr_pos, len, used);
          hdr_mem[np % RING_LINES]     = '0;
          hdr_mem[wr_pos % RING_LINES] = b.msg_size;
          wr_pos  = np;
          free_ln = (free_ln >= used) ? free_ln - used : 0;
        end
      end
    end else begin
      r.line_index = rd_pos[9:0];
      hd = 32'(hdr_mem[rd_pos % RING_LINES]);
      r.head_size = hd[15:0];
      if (hd == 0) begin
        r.status = ST_EMPTY;
      end else if (b.opcode == OP_RELEASE) begin
        len = line_count(hd);
        if (len > m) len = m;
        rd_pos  = step_pos(rd_pos, len, used);
        free_ln = free_ln + used;
        if (free_ln > ring_size()) free_ln = ring_size();
      end
    end
    r.free_count = free_ln[10:0];
    return r;
  endfunction

  function automatic void add_beat(op_e op, logic [15:0] sz, bit typed = 1'b0,
                                   status_e st = ST_OK, int unsigned idx = 0,
                                   int unsigned head = 0, int unsigned free = 0);
    dir_row_t row;
    row.kind              = ROW_ITEM;
    row.cfg_reg           = REG_MAX_MESSAGE_LINES;
    row.cfg_val           = '0;
    row.beat.opcode       = op;
    row.beat.msg_size     = sz;
    row.typed             = typed;
    row.want.status       = st;
    row.want.line_index   = idx[9:0];
    row.want.head_size    = head[15:0];
    row.want.free_count   = free[10:0];
    dir_tab.push_back(row);
  endfunction

  function automatic void add_cfg(reg_e r, logic [10:0] v);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.cfg_reg = r;
    row.cfg_val = v;
    row.beat    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_tab.push_back(row);
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int unsigned tx_gap();
    int unsigned r;
    if (tx_flat) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // random beat; commits mostly carry sizes that fit the current setting
  function automatic in_beat_t random_beat(int unsigned commit_pct);
    in_beat_t    b;
    int unsigned s;
    int unsigned fit;
    fit = LINE_BYTES * msg_cap() - HEADER_BYTES;
    b.msg_size = 16'($urandom);
    if ($urandom_range(0, 99) < commit_pct) begin
      b.opcode = OP_COMMIT;
      s = $urandom_range(0, 99);
      if (s < 85) b.msg_size = 16'($urandom_range(1, fit));
      else if (s < 90) b.msg_size = 16'(fit + 1);
      else if (s < 93) b.msg_size = '0;
    end else begin
      s = $urandom_range(0, 9);
      if (s < 6) b.opcode = OP_RELEASE;
      else if (s < 8) b.opcode = OP_PEEK;
      else b.opcode = OP_RESERVE;
    end
    return b;
  endfunction

  // offer one beat after a random gap; valid stays high across back-to-back beats
  task automatic push_beat(in_beat_t b, bit typed, out_beat_t typed_reply);
    int unsigned gap;
    out_beat_t   reply;
    gap = tx_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall);
    // accepted at this edge
    reply = ring_reply(b);
    reply_q.push_back(typed ? typed_reply : reply);
  endtask

  // drop valid, then wait until every reply has come back
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [10:0] val);
    wait_drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == REG_MAX_MESSAGE_LINES) cfg_max_raw = 32'(val & 11'h07F);
    else cfg_total_raw = 32'(val);
    ring_empty();
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // reply checker: each accepted result beat against the oldest expectation
  always @(posedge clk_i) begin : reply_check
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
      end else begin
        want = reply_q.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("line_index", 16'(want.line_index), 16'(out_data.line_index));
        check_field("head_size", want.head_size, out_data.head_size);
        check_field("free_count", 16'(want.free_count), 16'(out_data.free_count));
      end
    end
  end

  // receiver: clear stretches, short and long stalls, plus the long hold-off
  initial begin : rx_side
    int unsigned r;
    int unsigned n;
    bit          v;
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        v = 1'b1;
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else if (r < 15) begin
        v = 1'b0;
        n = $urandom_range(20, 50);
      end else if (r < 55) begin
        v = 1'b0;
        n = $urandom_range(1, 4);
      end else if (r < 92) begin
        v = 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        v = 1'b1;
        n = $urandom_range(10, 30);
      end
      out_stall <= v;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL variable_message_ring_manager");
    $finish;
  end

  initial begin : stimulus
    int unsigned commit_pct;
    logic [10:0] mx;
    logic [10:0] tt;
    out_beat_t   none;

    none = '0;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;

    // directed part, reset setting: two-line messages in a 1024-line ring
    add_beat(OP_PEEK, 16'h0000, 1'b1, ST_EMPTY, 0, 0, 1024);
    add_beat(OP_RELEASE, 16'hFFFF, 1'b1, ST_EMPTY, 0, 0, 1024);
    add_beat(OP_RESERVE, 16'hFFFF, 1'b1, ST_OK, 0, 0, 1024);
    // zero size would read as the sentinel
    add_beat(OP_COMMIT, 16'h0000, 1'b1, ST_BAD_SIZE, 0, 0, 1024);
    add_beat(OP_COMMIT, 16'hFFFF, 1'b1, ST_BAD_SIZE, 0, 0, 1024);
    // largest size that fits, then one byte over
    add_beat(OP_COMMIT, 16'd120);
    add_beat(OP_COMMIT, 16'd121);
    add_beat(OP_COMMIT, 16'd1);
    add_beat(OP_PEEK, 16'd0);
    add_beat(OP_RELEASE, 16'd0);
    add_beat(OP_RELEASE, 16'd0);
    add_beat(OP_RELEASE, 16'd0);
    // smallest ring: four lines, two-line messages
    add_cfg(REG_TOTAL_LINES, 11'd4);
    add_beat(OP_COMMIT, 16'd1, 1'b1, ST_OK, 0, 0, 3);
    add_beat(OP_RESERVE, 16'd0, 1'b1, ST_NO_SPACE, 1, 0, 3);
    // no space wins over a bad size
    add_beat(OP_COMMIT, 16'd0, 1'b1, ST_NO_SPACE, 1, 0, 3);
    add_beat(OP_RELEASE, 16'd0, 1'b1, ST_OK, 0, 1, 4);
    // wraps to line 0 with the tail counted as used
    add_beat(OP_COMMIT, 16'd120);
    add_beat(OP_PEEK, 16'd0);
    add_beat(OP_RELEASE, 16'd0);
    // register extremes: out-of-range values clamp
    add_cfg(REG_MAX_MESSAGE_LINES, 11'h7FF);
    add_cfg(REG_TOTAL_LINES, 11'd0);
    add_beat(OP_COMMIT, 16'd120);
    add_cfg(REG_MAX_MESSAGE_LINES, 11'd0);
    add_cfg(REG_TOTAL_LINES, 11'h7FF);
    add_beat(OP_COMMIT, 16'd56);
    add_beat(OP_COMMIT, 16'd57);
    add_beat(OP_RELEASE, 16'd0);
    add_beat(OP_RELEASE, 16'd0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].cfg_reg, dir_tab[i].cfg_val);
      else push_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    end

    // random part, one ring setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 10) begin
        mx = phase_max[p];
        tt = phase_total[p];
      end else begin
        mx = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(0, 80));
        tt = 11'($urandom_range(0, 1100));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_MAX_MESSAGE_LINES, mx);
        write_reg(REG_TOTAL_LINES, tt);
      end else begin
        write_reg(REG_TOTAL_LINES, tt);
        write_reg(REG_MAX_MESSAGE_LINES, mx);
      end
      // back the block up: receiver holds off, sender keeps offering
      if (p == 2 || p == 9) begin
        @(posedge clk_i);
        hold_req = 1'b1;
        tx_flat  = 1'b1;
      end
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // every 16 beats a new commit share is drawn at random, filling or draining
        if (k % 16 == 0) begin
          case ($urandom_range(0, 2))
            0: commit_pct = 80;
            1: commit_pct = 50;
            default: commit_pct = 20;
          endcase
        end
        if (k == PHASE_BEATS / 2) begin
          tx_flat = 1'b0;
          wait_drain();
        end
        push_beat(random_beat(commit_pct), 1'b0, none);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("PASS variable_message_ring_manager");
    end else begin
      $display("FAIL variable_message_ring_manager");
    end
    $finish;
  end

endmodule
